### hw/rtl/b64d_pkg.sv
// shared types and constants for the base64 stream decoder
package b64d_pkg;

  // result fifo geometry
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned MaxPush   = 3;

  localparam logic [15:0] MaxOutReset = 16'hFFFF;

  // ascii codes of the alphabet bounds
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChEquals = 8'h3D;

  localparam logic [5:0] SxLowerBase = 6'd26;
  localparam logic [5:0] SxDigitBase = 6'd52;
  localparam logic [5:0] SxPlus      = 6'd62;
  localparam logic [5:0] SxSlash     = 6'd63;

  // per-text decoding state
  typedef struct packed {
    logic [2:0][5:0] sextets;
    logic [1:0]      pos;
    logic            pad3;
    logic [15:0]     count;
    logic            discard;
  } dec_state_t;

  // one result item
  typedef struct packed {
    logic [15:0] out_count;
    logic        limit_hit;
    logic        stream_done;
    logic        last_of_run;
    logic        byte_valid;
    logic [7:0]  out_byte;
  } result_t;

endpackage

### hw/rtl/b64d_decode.sv
// next-state and result logic for one accepted character
module b64d_decode (
  input  logic [7:0]              in_char_i,
  input  logic                    end_i,
  input  logic [15:0]             max_i,
  input  b64d_pkg::dec_state_t    st_i,
  output b64d_pkg::dec_state_t    st_o,
  output b64d_pkg::result_t [2:0] res_o,
  output logic [1:0]              n_o
);

  logic       ok;
  logic [5:0] sx;
  logic       is_eq;
  logic [7:0] b0, b1, b2;
  logic [2:0][7:0] list;
  logic [1:0] ncand;
  logic       emit;
  logic       found;
  logic [1:0] hit_idx;
  logic [1:0] n;
  logic [2:0][15:0] cnt_k;
  b64d_pkg::dec_state_t st_nx;

  // sextet lookup
  always_comb begin
    ok = 1'b1;
    sx = '0;
    if (in_char_i >= b64d_pkg::ChUpperA && in_char_i <= b64d_pkg::ChUpperZ) begin
      sx = 6'(in_char_i - b64d_pkg::ChUpperA);
    end else if (in_char_i >= b64d_pkg::ChLowerA && in_char_i <= b64d_pkg::ChLowerZ) begin
      sx = 6'(in_char_i - b64d_pkg::ChLowerA) + b64d_pkg::SxLowerBase;
    end else if (in_char_i >= b64d_pkg::ChDigit0 && in_char_i <= b64d_pkg::ChDigit9) begin
      sx = 6'(in_char_i - b64d_pkg::ChDigit0) + b64d_pkg::SxDigitBase;
    end else if (in_char_i == b64d_pkg::ChPlus) begin
      sx = b64d_pkg::SxPlus;
    end else if (in_char_i == b64d_pkg::ChSlash || in_char_i == b64d_pkg::ChEquals) begin
      sx = b64d_pkg::SxSlash;
    end else begin
      ok = 1'b0;
    end
  end

  assign is_eq = (in_char_i == b64d_pkg::ChEquals);
  assign b0 = {st_i.sextets[0], st_i.sextets[1][5:4]};
  assign b1 = {st_i.sextets[1][3:0], st_i.sextets[2][5:2]};
  assign b2 = {st_i.sextets[2][1:0], sx};

  always_comb begin
    st_nx = st_i;
    emit  = 1'b0;
    ncand = '0;
    list  = '0;
    if (end_i) begin
      emit    = !st_i.discard;
      list[0] = b0;
      list[1] = b1;
      ncand   = 2'((st_i.pos >= 2'd2) ? 1 : 0)
              + 2'((st_i.pos == 2'd3 && !st_i.pad3) ? 1 : 0);
      st_nx   = '0;
    end else if (!st_i.discard && ok) begin
      if (st_i.pos != 2'd3) begin
        st_nx.sextets[st_i.pos] = sx;
        if (st_i.pos == 2'd2) begin
          st_nx.pad3 = is_eq;
        end
        st_nx.pos = st_i.pos + 2'd1;
      end else begin
        emit    = 1'b1;
        list[0] = b0;
        list[1] = st_i.pad3 ? b2 : b1;
        list[2] = b2;
        ncand   = 2'd1 + 2'(!st_i.pad3) + 2'(!is_eq);
        st_nx.pos  = '0;
        st_nx.pad3 = 1'b0;
      end
    end
  end

  // limit check on each candidate byte, first match wins
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < 3; k++) begin
      cnt_k[k] = st_i.count + 16'(k + 1);
      if (!found && 2'(k) < ncand && cnt_k[k] == max_i) begin
        found   = 1'b1;
        hit_idx = 2'(k);
      end
    end
  end

  always_comb begin
    res_o = '0;
    n     = '0;
    st_o  = st_nx;
    if (emit) begin
      if (ncand == 2'd0) begin
        // flush with fewer than two sextets held: a bare end marker
        n = 2'd1;
        res_o[0].out_count   = st_i.count;
        res_o[0].last_of_run = 1'b1;
        res_o[0].stream_done = 1'b1;
      end else begin
        n = found ? hit_idx + 2'd1 : ncand;
        for (int k = 0; k < 3; k++) begin
          res_o[k].out_byte    = list[k];
          res_o[k].byte_valid  = 1'b1;
          res_o[k].out_count   = cnt_k[k];
          res_o[k].last_of_run = (2'(k) == n - 2'd1);
          res_o[k].stream_done = (2'(k) == n - 2'd1) && (end_i || found);
          res_o[k].limit_hit   = (2'(k) == n - 2'd1) && found;
        end
      end
    end
    if (emit && !end_i) begin
      st_o.count   = st_i.count + 16'(n);
      st_o.discard = found;
    end
  end

  assign n_o = n;

endmodule

### hw/rtl/b64d_fifo.sv
// result queue: up to three pushes and one pop per cycle
module b64d_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [1:0]              push_n_i,
  input  b64d_pkg::result_t [2:0] push_data_i,
  input  logic                    pop_i,
  output logic                    room_o,
  output logic                    not_empty_o,
  output b64d_pkg::result_t       head_o
);

  b64d_pkg::result_t mem_q [b64d_pkg::FifoDepth];
  logic [b64d_pkg::PtrW-1:0] wr_q, rd_q;
  logic [b64d_pkg::CntW-1:0] cnt_q, cnt_d;
  logic pop;

  assign not_empty_o = (cnt_q != '0);
  assign pop    = pop_i && not_empty_o;
  assign room_o = (cnt_q <= b64d_pkg::CntW'(b64d_pkg::FifoDepth - b64d_pkg::MaxPush));
  assign head_o = mem_q[rd_q];
  assign cnt_d  = cnt_q + b64d_pkg::CntW'(push_n_i) - b64d_pkg::CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + b64d_pkg::PtrW'(push_n_i);
      rd_q  <= rd_q + b64d_pkg::PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_n_i) begin
        mem_q[wr_q + b64d_pkg::PtrW'(k)] <= push_data_i[k];
      end
    end
  end

endmodule

### hw/rtl/base64_stream_decoder_top.sv
// top level of the streaming base64 decoder
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready| in_char, end_of_text (tlast)
//  m_axis   | out | m_axis_tvalid/m_axis_tready| out_byte, out_count, flags, tlast
//  cfg      | in  | cfg_valid_i/cfg_ready_o    | max_out_size
//
// one character is accepted per cycle; its results are computed in the same
// cycle and written into an 8-entry result queue, which sends one item a cycle
// a character makes 0 to 3 results, so tready drops while fewer than 3 queue
// slots are free; with the output never stalled the rate is 1 character/cycle
// reset clears the text state, empties the queue and sets max_out_size to 65535
// an output stall fills the queue and then holds off input; nothing is lost
module base64_stream_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // end_of_text
  // decoded results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] out_count
  output logic [2:0]  m_axis_tuser,   // [0] byte_valid, [1] stream_done, [2] limit_hit
  output logic        m_axis_tlast,   // last_of_run
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // max_out_size
);

  b64d_pkg::dec_state_t    st_q, st_d;
  b64d_pkg::result_t [2:0] res;
  b64d_pkg::result_t       head;
  logic [1:0]  n;
  logic [15:0] max_q;
  logic        accept;
  logic        room;

  // config taken any time; user must write it only while the block is idle (unchecked)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= b64d_pkg::MaxOutReset;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  b64d_decode u_decode (
    .in_char_i (s_axis_tdata),
    .end_i     (s_axis_tlast),
    .max_i     (max_q),
    .st_i      (st_q),
    .st_o      (st_d),
    .res_o     (res),
    .n_o       (n)
  );

  // text state moves only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  b64d_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (accept ? n : 2'd0),
    .push_data_i (res),
    .pop_i       (m_axis_tready),
    .room_o      (room),
    .not_empty_o (m_axis_tvalid),
    .head_o      (head)
  );

  // unpack the queue head onto the output bus
  assign m_axis_tdata = {head.out_count, head.out_byte};
  assign m_axis_tuser = {head.limit_hit, head.stream_done, head.byte_valid};
  assign m_axis_tlast = head.last_of_run;

endmodule

### tb/sv/base64_stream_decoder_top_tb.sv
// self-checking testbench for the streaming base64 decoder top level
module base64_stream_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // run stops here if the decoder hangs
  localparam int unsigned CycleLimit = 200000;
  // results are queued in the same cycle, so a short settle covers anything in flight
  localparam int unsigned SettleCycles = 20;

  // one pending input item
  typedef struct {
    logic [7:0] ch;
    logic       eot;
    logic       drain_first;  // hold this item until every queued result has arrived
  } char_item_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_char
  logic        s_axis_tlast  = 1'b0; // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] out_byte, [23:8] out_count
  logic [2:0]  m_axis_tuser;         // [0] byte_valid, [1] stream_done, [2] limit_hit
  logic        m_axis_tlast;         // last_of_run
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;   // max_out_size

  base64_stream_decoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // stimulus and scoreboard storage
  char_item_t          char_q[$];     // characters waiting to be sent
  b64d_pkg::result_t   decoded_q[$];  // decoded results still owed by the block
  int unsigned items_queued;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // handshakes seen at the last rising edge, read by the falling-edge processes
  logic in_fire  = 1'b0;
  logic cfg_fire = 1'b0;

  // predictor copy of the decoder state
  logic [5:0]  held [3];
  logic [1:0]  grp_pos;
  logic        pad3;
  logic [15:0] byte_cnt;
  logic        discarding;
  logic [15:0] max_out = b64d_pkg::MaxOutReset;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // cycle counter doubles as the hang watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void restart_text();
    held[0]    = '0;
    held[1]    = '0;
    held[2]    = '0;
    grp_pos    = '0;
    pad3       = 1'b0;
    byte_cnt   = '0;
    discarding = 1'b0;
  endfunction

  // alphabet lookup; '=' decodes like '/'; -1 for characters that get skipped
  function automatic int sextet_of_char(input logic [7:0] c);
    if (c >= b64d_pkg::ChUpperA && c <= b64d_pkg::ChUpperZ)
      return int'(c - b64d_pkg::ChUpperA);
    if (c >= b64d_pkg::ChLowerA && c <= b64d_pkg::ChLowerZ)
      return int'(c - b64d_pkg::ChLowerA) + int'(b64d_pkg::SxLowerBase);
    if (c >= b64d_pkg::ChDigit0 && c <= b64d_pkg::ChDigit9)
      return int'(c - b64d_pkg::ChDigit0) + int'(b64d_pkg::SxDigitBase);
    if (c == b64d_pkg::ChPlus) return int'(b64d_pkg::SxPlus);
    if (c == b64d_pkg::ChSlash || c == b64d_pkg::ChEquals) return int'(b64d_pkg::SxSlash);
    return -1;
  endfunction

  // works out the results of one accepted character and queues them
  function automatic void decode_step(input logic [7:0] ch, input logic eot);
    logic [7:0]        bytes_out [3];
    b64d_pkg::result_t res [3];
    int         nb;
    int         nr;
    int         v;
    int         i;
    logic       hit;
    nb  = 0;
    nr  = 0;
    hit = 1'b0;
    if (eot) begin
      // end of text while discarding only clears the text
      if (discarding) begin
        restart_text();
        return;
      end
      // flush a partial group as if padded with zero sextets
      if (grp_pos >= 2) begin
        bytes_out[nb] = {held[0], held[1][5:4]};
        nb++;
      end
      if (grp_pos == 3 && !pad3) begin
        bytes_out[nb] = {held[1][3:0], held[2][5:2]};
        nb++;
      end
    end else begin
      if (discarding) return;
      v = sextet_of_char(ch);
      if (v < 0) return;
      if (grp_pos < 3) begin
        held[grp_pos] = v[5:0];
        if (grp_pos == 2) pad3 = (ch == b64d_pkg::ChEquals);
        grp_pos++;
        return;
      end
      // fourth member completes the group; padding drops the trailing bytes
      bytes_out[0] = {held[0], held[1][5:4]};
      nb = 1;
      if (!pad3) begin
        bytes_out[nb] = {held[1][3:0], held[2][5:2]};
        nb++;
      end
      if (ch != b64d_pkg::ChEquals) begin
        bytes_out[nb] = {held[2][1:0], v[5:0]};
        nb++;
      end
      grp_pos = '0;
      pad3    = 1'b0;
    end
    // emit bytes, stopping at the one that reaches the limit
    for (i = 0; i < nb && !hit; i++) begin
      byte_cnt           = byte_cnt + 16'd1;
      res[nr]            = '0;
      res[nr].out_byte   = bytes_out[i];
      res[nr].byte_valid = 1'b1;
      res[nr].out_count  = byte_cnt;
      nr++;
      hit = (byte_cnt == max_out);
    end
    // end of text with nothing to flush still reports that the text is done
    if (nr == 0) begin
      res[0]           = '0;
      res[0].out_count = byte_cnt;
      nr               = 1;
    end
    res[nr-1].last_of_run = 1'b1;
    if (eot || hit) begin
      res[nr-1].stream_done = 1'b1;
      res[nr-1].limit_hit   = hit;
    end
    for (i = 0; i < nr; i++) decoded_q.push_back(res[i]);
    if (eot) restart_text();
    else if (hit) discarding = 1'b1;
  endfunction

  initial restart_text();

  // ---------------------------------------------------------------------------
  // driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------

  logic       next_valid;
  char_item_t next_item;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // keep the current item up until it has been taken
      next_valid = s_axis_tvalid && !in_fire;
      if (!next_valid && char_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(char_q[0].drain_first && decoded_q.size() != 0)) begin
        next_item = char_q.pop_front();
        s_axis_tdata <= next_item.ch;
        s_axis_tlast <= next_item.eot;
        next_valid = 1'b1;
      end
      s_axis_tvalid <= next_valid;
      // output stalls are independent of the input side
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: everything sampled on the rising edge
  // ---------------------------------------------------------------------------

  b64d_pkg::result_t got_r;
  b64d_pkg::result_t exp_r;

  always @(posedge clk_i) begin
    in_fire  <= s_axis_tvalid && s_axis_tready;
    cfg_fire <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) max_out = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) decode_step(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.out_byte    = m_axis_tdata[7:0];
        got_r.out_count   = m_axis_tdata[23:8];
        got_r.byte_valid  = m_axis_tuser[0];
        got_r.stream_done = m_axis_tuser[1];
        got_r.limit_hit   = m_axis_tuser[2];
        got_r.last_of_run = m_axis_tlast;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result byte=%h valid=%b last=%b done=%b limit=%b count=%0d",
                     $time, got_r.out_byte, got_r.byte_valid, got_r.last_of_run,
                     got_r.stream_done, got_r.limit_hit, got_r.out_count);
        end else begin
          exp_r = decoded_q.pop_front();
          if (got_r !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: mismatch exp byte=%h valid=%b last=%b done=%b limit=%b count=%0d",
                     $time, exp_r.out_byte, exp_r.byte_valid, exp_r.last_of_run,
                     exp_r.stream_done, exp_r.limit_hit, exp_r.out_count);
              $display(" got byte=%h valid=%b last=%b done=%b limit=%b count=%0d",
                       got_r.out_byte, got_r.byte_valid, got_r.last_of_run,
                       got_r.stream_done, got_r.limit_hit, got_r.out_count);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_item(input logic [7:0] ch, input logic eot, input logic drain = 1'b0);
    char_item_t it;
    it.ch          = ch;
    it.eot         = eot;
    it.drain_first = drain;
    char_q.push_back(it);
    items_queued++;
  endtask

  // end of text carries a random character that must be ignored
  task automatic queue_eot();
    queue_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] char_of_sextet(input int s);
    if (s < int'(b64d_pkg::SxLowerBase)) return b64d_pkg::ChUpperA + 8'(s);
    if (s < int'(b64d_pkg::SxDigitBase))
      return b64d_pkg::ChLowerA + 8'(s - int'(b64d_pkg::SxLowerBase));
    if (s < int'(b64d_pkg::SxPlus))
      return b64d_pkg::ChDigit0 + 8'(s - int'(b64d_pkg::SxDigitBase));
    if (s == int'(b64d_pkg::SxPlus)) return b64d_pkg::ChPlus;
    return b64d_pkg::ChSlash;
  endfunction

  // noisy texts sprinkle random bytes; loose texts also put '=' anywhere
  task automatic queue_member(input int kind);
    if (kind >= 7 && $urandom_range(3) == 0) queue_item(8'($urandom_range(255)), 1'b0);
    if (kind == 9 && $urandom_range(3) == 0) queue_item(b64d_pkg::ChEquals, 1'b0);
    else queue_item(char_of_sextet($urandom_range(63)), 1'b0);
  endtask

  // one text: whole groups, an optional tail (partial or padded), then end of text
  task automatic queue_random_text();
    int kind;
    int groups;
    int tail;
    int g;
    kind   = $urandom_range(9);
    groups = $urandom_range(4);
    tail   = $urandom_range(5);
    for (g = 0; g < groups * 4; g++) queue_member(kind);
    case (tail)
      1, 2, 3: begin
        for (g = 0; g < tail; g++) queue_member(kind);
      end
      4: begin
        queue_member(kind);
        queue_member(kind);
        queue_item(b64d_pkg::ChEquals, 1'b0);
        queue_item(b64d_pkg::ChEquals, 1'b0);
      end
      5: begin
        for (g = 0; g < 3; g++) queue_member(kind);
        queue_item(b64d_pkg::ChEquals, 1'b0);
      end
      default: ;
    endcase
    queue_eot();
  endtask

  // block is idle once every item is sent and every result has come back,
  // seen over settle falling edges in a row
  task automatic wait_idle(input int unsigned settle);
    int unsigned quiet;
    quiet = 0;
    while (quiet < settle) begin
      @(negedge clk_i);
      if (char_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) quiet = 0;
      else quiet++;
    end
  endtask

  task automatic write_max_out(input logic [15:0] val);
    @(negedge clk_i);
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [15:0] limit, input int unsigned n_items,
                                  input logic drain_pause);
    wait_idle(8);
    write_max_out(limit);
    items_queued = 0;
    while (items_queued < n_items) begin
      // pressure: halfway through, a character waits until the block has nothing left to send
      if (drain_pause && items_queued >= n_items / 2) begin
        queue_item(char_of_sextet($urandom_range(63)), 1'b0, 1'b1);
        drain_pause = 1'b0;
      end
      queue_random_text();
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    send_idle_pct = 26;
    recv_idle_pct = 68;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: default limit written explicitly
    write_max_out(b64d_pkg::MaxOutReset);
    queue_text("+/az");             // extreme alphabet members, full group
    queue_item(8'h00, 1'b0);        // skipped bytes with all bits low and high
    queue_item(8'hFF, 1'b0);
    queue_text("TW==");             // pad in third place: one byte
    queue_text("TWE=");             // pad in fourth place: two bytes
    queue_eot();                    // nothing held: done marker only
    queue_text("TWE");              // three held at end of text
    queue_eot();
    queue_text("TW");               // two held at end of text
    queue_eot();
    queue_text("T");                // one held: no byte, done marker only
    queue_eot();

    // random texts across limits and stall patterns
    run_random_phase(16'd1, 30, 1'b0);
    send_idle_pct = 68;
    recv_idle_pct = 26;
    run_random_phase(16'd2, 30, 1'b0);
    run_random_phase(16'd7, 30, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(b64d_pkg::MaxOutReset, 40, 1'b0);

    wait_idle(SettleCycles);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_decode.sv
hw/rtl/b64d_fifo.sv
hw/rtl/base64_stream_decoder_top.sv
tb/sv/base64_stream_decoder_top_tb.sv
